FILE: design/akf_pkg.sv
// Shared constants, types and helpers for the adaptive Kalman filter.
// Used by akf_ring, akf_root and adaptive_kalman_filter; no dependencies.
`timescale 1ns / 1ps

package akf_pkg;

  // Ring of recent samples.
  localparam int WINDOW_SLOTS = 32;
  localparam int POS_W        = $clog2(WINDOW_SLOTS);
  localparam int SLOTS_W      = $clog2(WINDOW_SLOTS + 1);

  // Field and datapath widths.
  localparam int SMP_W   = 16;
  localparam int OUT_W   = 32;
  localparam int WIN_W   = 5;
  localparam int Q_W     = 32;
  localparam int CFG_W   = 32;
  localparam int CIDX_W  = 2;
  localparam int X_W     = 40;
  localparam int P_W     = 64;
  localparam int K_W     = 17;
  localparam int SUM_W   = 22;
  localparam int SQ_W    = 38;
  localparam int PROD_W  = 44;
  localparam int NABS_W  = 44;
  localparam int ROOT_W  = NABS_W / 2 + 32;
  localparam int DEN_W   = 48;

  // Register indexes.
  localparam logic [CIDX_W-1:0] REG_PROCESS_NOISE = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_WINDOW        = CIDX_W'(1);

  // Main sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_NORM,
    ST_DIV,
    ST_MUL,
    ST_CORR,
    ST_DONE
  } akf_state_t;

  // Ring update states.
  typedef enum logic [1:0] {
    RG_IDLE,
    RG_WRITE,
    RG_READ,
    RG_SUB
  } ring_state_t;

  // Status from the ring: pulse with the updated running sums.
  typedef struct packed {
    logic                    done;
    logic signed [SUM_W-1:0] sum;
    logic signed [SQ_W-1:0]  sq;
  } ring_stat_t;

  // Status from the root unit: pulse with the new noise value.
  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] value;
  } root_stat_t;

  // Number of ring slots in use for a window setting.
  function automatic logic [SLOTS_W-1:0] slot_count(input logic [WIN_W-1:0] w);
    int n;
    n = int'(w) + 1;
    if (n > WINDOW_SLOTS) begin
      n = WINDOW_SLOTS;
    end
    return SLOTS_W'(n);
  endfunction

  // Divisor of the variance: slots less one, never below one.
  function automatic logic [WIN_W-1:0] noise_div(input logic [WIN_W-1:0] w);
    int n;
    n = int'(slot_count(w));
    if (n > 1) begin
      return WIN_W'(n - 1);
    end
    return WIN_W'(1);
  endfunction

endpackage

FILE: design/akf_ring.sv
// Sample ring with valid bits and running sum and square sum.
// Depends on akf_pkg.
`timescale 1ns / 1ps

module akf_ring (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [akf_pkg::SMP_W-1:0]    sample,
  input  logic [akf_pkg::WIN_W-1:0]           window,
  output akf_pkg::ring_stat_t                 stat
);

  akf_pkg::ring_state_t state_r, state_nxt;

  logic signed [akf_pkg::SMP_W-1:0] ring_mem [akf_pkg::WINDOW_SLOTS];
  logic [akf_pkg::WINDOW_SLOTS-1:0] valid_r;
  logic [akf_pkg::POS_W-1:0]        pos_r;
  logic signed [akf_pkg::SUM_W-1:0] sum_r;
  logic signed [akf_pkg::SQ_W-1:0]  sq_r;
  logic signed [akf_pkg::SMP_W-1:0] rd_r;
  logic                             rv_r;
  logic                             done_r;

  logic                             wr_en, rd_en, sub_en;
  logic [akf_pkg::SLOTS_W-1:0]      pos_inc;
  logic [akf_pkg::SLOTS_W-1:0]      slots;
  logic signed [akf_pkg::SMP_W-1:0] old_v;
  logic [2*akf_pkg::SMP_W-1:0]      new_sq, old_sq;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      akf_pkg::RG_IDLE:  if (start) state_nxt = akf_pkg::RG_WRITE;
      akf_pkg::RG_WRITE: state_nxt = akf_pkg::RG_READ;
      akf_pkg::RG_READ:  state_nxt = akf_pkg::RG_SUB;
      akf_pkg::RG_SUB:   state_nxt = akf_pkg::RG_IDLE;
      default:           state_nxt = akf_pkg::RG_IDLE;
    endcase
  end

  // Strobes per state.
  always_comb begin
    wr_en  = 1'b0;
    rd_en  = 1'b0;
    sub_en = 1'b0;
    case (state_r)
      akf_pkg::RG_WRITE: wr_en  = 1'b1;
      akf_pkg::RG_READ:  rd_en  = 1'b1;
      akf_pkg::RG_SUB:   sub_en = 1'b1;
      default: ;
    endcase
  end

  // Position advance, wrapping at the slot count.
  assign slots   = akf_pkg::slot_count(window);
  assign pos_inc = akf_pkg::SLOTS_W'(pos_r) + akf_pkg::SLOTS_W'(1);
  assign old_v   = rv_r ? rd_r : '0;
  assign new_sq  = $unsigned((2*akf_pkg::SMP_W)'(sample) * (2*akf_pkg::SMP_W)'(sample));
  assign old_sq  = $unsigned((2*akf_pkg::SMP_W)'(old_v) * (2*akf_pkg::SMP_W)'(old_v));

  // Storage: written at the current slot, then the next slot is read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[pos_r] <= sample;
    end
    if (rd_en) begin
      rd_r <= ring_mem[pos_r];
      rv_r <= valid_r[pos_r];
    end
  end

  // Control, position and sums.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= akf_pkg::RG_IDLE;
      valid_r <= '0;
      pos_r   <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= sub_en;
      if (wr_en) begin
        valid_r[pos_r] <= 1'b1;
        sum_r <= sum_r + akf_pkg::SUM_W'(sample);
        sq_r  <= sq_r + $signed(akf_pkg::SQ_W'(new_sq));
        if (pos_inc >= slots) begin
          pos_r <= '0;
        end else begin
          pos_r <= pos_inc[akf_pkg::POS_W-1:0];
        end
      end
      if (sub_en) begin
        sum_r <= sum_r - akf_pkg::SUM_W'(old_v);
        sq_r  <= sq_r - $signed(akf_pkg::SQ_W'(old_sq));
      end
    end
  end

  assign stat.done = done_r;
  assign stat.sum  = sum_r;
  assign stat.sq   = sq_r;

endmodule

FILE: design/akf_root.sv
// Bit-serial square root of n * 2^64 with the root divided by a small
// divisor as its bits appear. Depends on akf_pkg.
`timescale 1ns / 1ps

module akf_root (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [akf_pkg::NABS_W-1:0]    nabs,
  input  logic [akf_pkg::WIN_W-1:0]     divisor,
  output akf_pkg::root_stat_t           stat
);

  localparam int REM_W = akf_pkg::ROOT_W + 4;
  localparam int CNT_W = $clog2(akf_pkg::ROOT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(akf_pkg::ROOT_W - 1);

  logic                           busy_r, done_r;
  logic [CNT_W-1:0]               cnt_r;
  logic [akf_pkg::NABS_W-1:0]     nsh_r;
  logic [REM_W-1:0]               rem_r;
  logic [akf_pkg::ROOT_W-1:0]     root_r;
  logic [akf_pkg::WIN_W-1:0]      d_r;
  logic [akf_pkg::WIN_W-1:0]      drem_r;
  logic [akf_pkg::ROOT_W-1:0]     quot_r;

  logic [REM_W-1:0]               rem_sh, trial;
  logic                           ge;
  logic [akf_pkg::WIN_W:0]        dsh;
  logic                           qbit;

  // One root bit per cycle; two radicand bits shift in each step.
  assign rem_sh = {rem_r[REM_W-3:0], nsh_r[akf_pkg::NABS_W-1 -: 2]};
  assign trial  = REM_W'({root_r, 2'b01});
  assign ge     = rem_sh >= trial;

  // The new root bit enters the long division by the divisor.
  assign dsh  = {drem_r, ge};
  assign qbit = dsh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (start) begin
      nsh_r  <= nabs;
      rem_r  <= '0;
      root_r <= '0;
      d_r    <= divisor;
      drem_r <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      nsh_r  <= {nsh_r[akf_pkg::NABS_W-3:0], 2'b00};
      rem_r  <= ge ? rem_sh - trial : rem_sh;
      root_r <= {root_r[akf_pkg::ROOT_W-2:0], ge};
      drem_r <= qbit ? akf_pkg::WIN_W'(dsh - {1'b0, d_r})
                     : dsh[akf_pkg::WIN_W-1:0];
      quot_r <= {quot_r[akf_pkg::ROOT_W-2:0], qbit};
    end
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.done  = done_r;
  assign stat.value = quot_r;

endmodule

FILE: design/adaptive_kalman_filter.sv
// Top level of the adaptive scalar Kalman filter.
// Depends on akf_pkg, akf_ring and akf_root.
`timescale 1ns / 1ps

//  Channel  Direction  Handshake           Payload
//  in       input      in_valid/in_ready   in_sample    (16 bits signed)
//  out      output     out_valid/out_ready out_estimate (32 bits signed, Q16.16)
//  cfg      input      cfg_we              cfg_index, cfg_data (32 bits)
//
// The time from acceptance to result is set by the 54-step square-root and
// divide unit that forms the next noise value; the gain and covariance path
// (up to 17 scaling steps, 17 divide steps, 17 multiply steps) runs beside
// it. One item is in work at a time.
// Synchronous active-low reset clears the filter state and the ring valid bits.
// A result waiting in the output register holds the sequencer before its
// next result until it is taken.

module adaptive_kalman_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [akf_pkg::SMP_W-1:0]    in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [akf_pkg::OUT_W-1:0]    out_estimate,
  input  logic                                cfg_we,
  input  logic [akf_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [akf_pkg::CFG_W-1:0]           cfg_data
);

  localparam int DIFF_W = akf_pkg::X_W + 2;
  localparam int KD_W   = DIFF_W + akf_pkg::K_W + 1;
  localparam int PM_W   = akf_pkg::P_W + akf_pkg::K_W;
  localparam int XS_W   = akf_pkg::X_W + 5;
  localparam int NUM_W  = akf_pkg::PROD_W + 2;
  localparam int CNT_W  = $clog2(akf_pkg::K_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(akf_pkg::K_W - 1);

  akf_pkg::akf_state_t state_r, state_nxt;

  // Configuration.
  logic [akf_pkg::Q_W-1:0]   q_r;
  logic [akf_pkg::WIN_W-1:0] w_r;

  // Filter state.
  logic signed [akf_pkg::X_W-1:0] x_r, xb_r;
  logic [akf_pkg::P_W-1:0]        p_r, r_r;
  logic                           noise_ok_r;

  // Working registers.
  logic signed [akf_pkg::SMP_W-1:0] s_r;
  logic signed [akf_pkg::X_W-1:0]   pred_r;
  logic signed [DIFF_W-1:0]         diff_r;
  logic [akf_pkg::P_W-1:0]          a_r, b_r;
  logic [akf_pkg::DEN_W-1:0]        den_r;
  logic [akf_pkg::DEN_W:0]          rem_r;
  logic [akf_pkg::K_W-1:0]          k_r, ksh_r, msh_r;
  logic signed [KD_W-1:0]           kd_r;
  logic [PM_W-1:0]                  pm_r;
  logic [CNT_W-1:0]                 cnt_r;

  // Noise path.
  logic signed [akf_pkg::PROD_W-1:0] sqd_r, sum2_r;
  logic                              n1_v_r, root_go_r;
  logic [akf_pkg::NABS_W-1:0]        nabs_r;

  // Output register.
  logic                           out_valid_r;
  logic signed [akf_pkg::OUT_W-1:0] out_est_r;

  // Strobes.
  logic ring_start, out_load;

  // Combinational datapath.
  logic signed [XS_W-1:0]      pred_sum, corr_sum;
  logic signed [akf_pkg::X_W-1:0] pred_sat, corr_sat;
  logic [akf_pkg::P_W:0]       pq_sum;
  logic [akf_pkg::P_W-1:0]     p_grown;
  logic [akf_pkg::P_W:0]       ab_sum;
  logic                        norm_fit;
  logic                        div_ge;
  logic [akf_pkg::DEN_W:0]     rem_sub;
  logic [akf_pkg::K_W-1:0]     k_fin;
  logic signed [NUM_W-1:0]     num;
  logic [NUM_W-1:0]            num_abs;
  logic [akf_pkg::WIN_W-1:0]   div_d;

  akf_pkg::ring_stat_t ring_stat;
  akf_pkg::root_stat_t root_stat;

  // Saturate a wide estimate to the 40-bit range.
  function automatic logic signed [akf_pkg::X_W-1:0] sat_x(input logic signed [XS_W-1:0] v);
    if (v[XS_W-1:akf_pkg::X_W-1] == '0 || v[XS_W-1:akf_pkg::X_W-1] == '1) begin
      return v[akf_pkg::X_W-1:0];
    end
    return v[XS_W-1] ? {1'b1, {(akf_pkg::X_W-1){1'b0}}} : {1'b0, {(akf_pkg::X_W-1){1'b1}}};
  endfunction

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      akf_pkg::ST_IDLE: if (in_valid) state_nxt = akf_pkg::ST_PRED;
      akf_pkg::ST_PRED: state_nxt = akf_pkg::ST_NORM;
      akf_pkg::ST_NORM: if (norm_fit) state_nxt = akf_pkg::ST_DIV;
      akf_pkg::ST_DIV:  if (cnt_r == CNT_LAST) state_nxt = akf_pkg::ST_MUL;
      akf_pkg::ST_MUL:  if (cnt_r == CNT_LAST) state_nxt = akf_pkg::ST_CORR;
      akf_pkg::ST_CORR: state_nxt = akf_pkg::ST_DONE;
      akf_pkg::ST_DONE: begin
        if (noise_ok_r && (!out_valid_r || out_ready)) state_nxt = akf_pkg::ST_IDLE;
      end
      default: state_nxt = akf_pkg::ST_IDLE;
    endcase
  end

  // Strobes per state.
  always_comb begin
    in_ready   = 1'b0;
    ring_start = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      akf_pkg::ST_IDLE: in_ready = 1'b1;
      akf_pkg::ST_PRED: ring_start = 1'b1;
      akf_pkg::ST_DONE: out_load = noise_ok_r && (!out_valid_r || out_ready);
      default: ;
    endcase
  end

  // Prediction: extrapolate the estimate and grow the covariance.
  assign pred_sum = XS_W'(x_r) + XS_W'(x_r) - XS_W'(xb_r);
  assign pred_sat = sat_x(pred_sum);
  assign pq_sum   = {1'b0, p_r} + (akf_pkg::P_W + 1)'(q_r);
  assign p_grown  = pq_sum[akf_pkg::P_W] ? '1 : pq_sum[akf_pkg::P_W-1:0];

  // Scaling so that the gain denominator fits 48 bits.
  assign ab_sum   = {1'b0, a_r} + {1'b0, b_r};
  assign norm_fit = (ab_sum[akf_pkg::P_W:akf_pkg::DEN_W] == '0);

  // Restoring division for the gain, one quotient bit a cycle.
  assign div_ge  = (den_r != '0) && (rem_r >= {1'b0, den_r});
  assign rem_sub = div_ge ? rem_r - {1'b0, den_r} : rem_r;
  assign k_fin   = {k_r[akf_pkg::K_W-2:0], div_ge};

  // Correction of the estimate; the product is shifted down with its sign.
  assign corr_sum = XS_W'(pred_r) + XS_W'($signed(kd_r[KD_W-1:16]));
  assign corr_sat = sat_x(corr_sum);

  // Variance numerator for the noise.
  assign div_d   = akf_pkg::noise_div(w_r);
  assign num     = NUM_W'(sqd_r) - NUM_W'(sum2_r);
  assign num_abs = num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);

  // Sequenced datapath.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_r <= in_sample;
    end
    case (state_r)
      akf_pkg::ST_PRED: begin
        pred_r <= pred_sat;
        diff_r <= $signed({{(DIFF_W-32){s_r[akf_pkg::SMP_W-1]}}, s_r, 16'h0000})
                  - DIFF_W'(pred_sat);
        a_r    <= p_grown;
        b_r    <= r_r;
      end
      akf_pkg::ST_NORM: begin
        if (norm_fit) begin
          den_r <= ab_sum[akf_pkg::DEN_W-1:0];
          rem_r <= {1'b0, a_r[akf_pkg::DEN_W-1:0]};
          k_r   <= '0;
        end else begin
          a_r <= a_r >> 1;
          b_r <= b_r >> 1;
        end
      end
      akf_pkg::ST_DIV: begin
        rem_r <= {rem_sub[akf_pkg::DEN_W-1:0], 1'b0};
        k_r   <= k_fin;
        if (cnt_r == CNT_LAST) begin
          ksh_r <= k_fin;
          msh_r <= akf_pkg::K_W'(1 << 16) - k_fin;
          kd_r  <= '0;
          pm_r  <= '0;
        end
      end
      akf_pkg::ST_MUL: begin
        kd_r  <= {kd_r[KD_W-2:0], 1'b0}
                 + (ksh_r[akf_pkg::K_W-1] ? KD_W'(diff_r) : '0);
        pm_r  <= {pm_r[PM_W-2:0], 1'b0}
                 + (msh_r[akf_pkg::K_W-1] ? PM_W'(p_r) : '0);
        ksh_r <= {ksh_r[akf_pkg::K_W-2:0], 1'b0};
        msh_r <= {msh_r[akf_pkg::K_W-2:0], 1'b0};
      end
      default: ;
    endcase
    // Noise products, then the magnitude for the root unit.
    if (ring_stat.done) begin
      sqd_r  <= akf_pkg::PROD_W'(ring_stat.sq)
                * akf_pkg::PROD_W'($signed({1'b0, div_d}));
      sum2_r <= akf_pkg::PROD_W'(ring_stat.sum) * akf_pkg::PROD_W'(ring_stat.sum);
    end
    if (n1_v_r) begin
      nabs_r <= num_abs[akf_pkg::NABS_W-1:0];
    end
    if (out_load) begin
      if (x_r[akf_pkg::X_W-1:akf_pkg::OUT_W-1] == '0
          || x_r[akf_pkg::X_W-1:akf_pkg::OUT_W-1] == '1) begin
        out_est_r <= x_r[akf_pkg::OUT_W-1:0];
      end else if (x_r[akf_pkg::X_W-1]) begin
        out_est_r <= {1'b1, {(akf_pkg::OUT_W-1){1'b0}}};
      end else begin
        out_est_r <= {1'b0, {(akf_pkg::OUT_W-1){1'b1}}};
      end
    end
  end

  // Control, configuration and filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= akf_pkg::ST_IDLE;
      q_r         <= akf_pkg::Q_W'(4295);
      w_r         <= akf_pkg::WIN_W'(7);
      x_r         <= '0;
      xb_r        <= '0;
      p_r         <= '0;
      r_r         <= '0;
      noise_ok_r  <= 1'b0;
      cnt_r       <= '0;
      n1_v_r      <= 1'b0;
      root_go_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      n1_v_r    <= ring_stat.done;
      root_go_r <= n1_v_r;
      if (cfg_we) begin
        case (cfg_index)
          akf_pkg::REG_PROCESS_NOISE: q_r <= cfg_data[akf_pkg::Q_W-1:0];
          akf_pkg::REG_WINDOW:        w_r <= cfg_data[akf_pkg::WIN_W-1:0];
          default: ;
        endcase
      end
      if (state_r == akf_pkg::ST_DIV || state_r == akf_pkg::ST_MUL) begin
        cnt_r <= (cnt_r == CNT_LAST) ? '0 : cnt_r + CNT_W'(1);
      end else begin
        cnt_r <= '0;
      end
      if (state_r == akf_pkg::ST_PRED) begin
        xb_r       <= pred_sat;
        p_r        <= p_grown;
        noise_ok_r <= 1'b0;
      end
      if (state_r == akf_pkg::ST_CORR) begin
        x_r <= corr_sat;
        p_r <= pm_r[PM_W-2:16];
      end
      if (root_stat.done) begin
        r_r        <= akf_pkg::P_W'(root_stat.value);
        noise_ok_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  akf_ring u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ring_start),
    .sample (s_r),
    .window (w_r),
    .stat   (ring_stat)
  );

  akf_root u_root (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (root_go_r),
    .nabs    (nabs_r),
    .divisor (div_d),
    .stat    (root_stat)
  );

  assign out_valid    = out_valid_r;
  assign out_estimate = out_est_r;

endmodule

FILE: tb/tb_adaptive_kalman_filter.sv
// Self-checking testbench for the adaptive scalar Kalman filter.
// Depends on akf_pkg and adaptive_kalman_filter; a bit-exact predictor checks every estimate but typed ones.
`timescale 1ns / 1ps

module tb_adaptive_kalman_filter;

  localparam longint EST_MAX    = 64'sd549755813887;
  localparam longint EST_MIN    = -64'sd549755813888;
  localparam int     STALL_LIMIT = 5000;

  typedef struct {
    logic signed [akf_pkg::SMP_W-1:0] smp;
    bit                               typed;
    logic signed [akf_pkg::OUT_W-1:0] want;
  } stim_row_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic signed [akf_pkg::SMP_W-1:0]  in_sample = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [akf_pkg::OUT_W-1:0]  out_estimate;
  logic                              cfg_we = 1'b0;
  logic [akf_pkg::CIDX_W-1:0]        cfg_index = '0;
  logic [akf_pkg::CFG_W-1:0]         cfg_data = '0;

  // Predictor state and its copy of the registers.
  longint                            x_now, x_prev;
  bit [63:0]                         p_cov, r_noise;
  bit [akf_pkg::Q_W-1:0]             q_reg;
  bit [akf_pkg::WIN_W-1:0]           win_reg;
  logic signed [akf_pkg::SMP_W-1:0]  ring [akf_pkg::WINDOW_SLOTS];
  int                                pos;
  bit [akf_pkg::SUM_W-1:0]           win_sum;
  bit [akf_pkg::SQ_W-1:0]            win_sq;

  logic signed [akf_pkg::OUT_W-1:0]  pending_estimates [$];
  int                                fail_count = 0;
  int                                idle_pct = 0;
  int                                stall_pct = 0;
  int                                quiet_cycles = 0;
  stim_row_t                         rows [16];

  adaptive_kalman_filter dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_estimate (out_estimate),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic longint clip40(input longint v);
    if (v > EST_MAX) return EST_MAX;
    if (v < EST_MIN) return EST_MIN;
    return v;
  endfunction

  // Bitwise square root of n * 2^64, so the result carries 32 fraction bits.
  function automatic bit [63:0] scaled_root(input bit [63:0] n);
    bit [63:0] root;
    bit [63:0] rem;
    bit [63:0] trial;
    bit [63:0] pair;
    root = '0;
    rem  = '0;
    for (int i = 63; i >= 0; i--) begin
      pair  = (i >= 32) ? ((n >> (2 * (i - 32))) & 64'd3) : 64'd0;
      rem   = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      root  = root << 1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = root | 64'd1;
      end
    end
    return root;
  endfunction

  // One filter step: extrapolate, gain, correct, then refresh the noise from the ring.
  task automatic filter_step(input logic signed [akf_pkg::SMP_W-1:0] smp,
                             output logic signed [akf_pkg::OUT_W-1:0] est);
    longint    sv, pred, diff, oldv, sums, sqs, num, e;
    bit [63:0] psum, pp, rr, den, gain, m, nabs;
    int        slots, dv;
    sv     = smp;
    pred   = clip40(2 * x_now - x_prev);
    x_prev = pred;
    psum   = p_cov + 64'(q_reg);
    p_cov  = (psum < p_cov) ? '1 : psum;

    pp = p_cov;
    rr = r_noise;
    while ((pp + rr) < pp || (pp + rr) >= 64'h0001_0000_0000_0000) begin
      pp = pp >> 1;
      rr = rr >> 1;
    end
    den  = pp + rr;
    gain = (den == 0) ? 64'd0 : (pp << 16) / den;

    diff  = sv * 65536 - pred;
    x_now = clip40(pred + ((longint'(gain) * diff) >>> 16));
    m     = 64'd65536 - gain;
    p_cov = (p_cov >> 16) * m + (((p_cov & 64'hFFFF) * m) >> 16);

    // Ring update with running sums that wrap at their widths.
    slots = int'(win_reg) + 1;
    if (slots > akf_pkg::WINDOW_SLOTS) slots = akf_pkg::WINDOW_SLOTS;
    dv = (slots > 1) ? slots - 1 : 1;
    ring[pos] = smp;
    win_sum = win_sum + akf_pkg::SUM_W'(sv);
    win_sq  = win_sq + akf_pkg::SQ_W'(sv * sv);
    pos = pos + 1;
    if (pos >= slots) pos = 0;
    oldv    = ring[pos];
    win_sum = win_sum - akf_pkg::SUM_W'(oldv);
    win_sq  = win_sq - akf_pkg::SQ_W'(oldv * oldv);

    sums    = longint'($signed(win_sum));
    sqs     = longint'($signed(win_sq));
    num     = sqs * dv - sums * sums;
    nabs    = (num < 0) ? 64'(-num) : 64'(num);
    r_noise = scaled_root(nabs) / 64'(dv);

    e = x_now;
    if (e > 64'sd2147483647) e = 64'sd2147483647;
    if (e < -64'sd2147483648) e = -64'sd2147483648;
    est = akf_pkg::OUT_W'(e);
  endtask

  // Offers one item, holding it until accepted, then records its expected estimate.
  task automatic send_sample(input logic signed [akf_pkg::SMP_W-1:0] smp, input bit typed,
                             input logic signed [akf_pkg::OUT_W-1:0] want);
    logic signed [akf_pkg::OUT_W-1:0] est;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_sample <= smp;
    do @(posedge clk); while (!in_ready);
    filter_step(smp, est);
    pending_estimates.push_back(typed ? want : est);
  endtask

  task automatic write_reg(input logic [akf_pkg::CIDX_W-1:0] idx,
                           input logic [akf_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == akf_pkg::REG_PROCESS_NOISE) q_reg = val;
    else if (idx == akf_pkg::REG_WINDOW) win_reg = val[akf_pkg::WIN_W-1:0];
  endtask

  // Lets the block fall idle: every estimate in, then a margin for the item in work.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic signed [akf_pkg::SMP_W-1:0] random_sample(input int level);
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
    if (pick < 45) return akf_pkg::SMP_W'(level + $urandom_range(64) - 32);
    return akf_pkg::SMP_W'($urandom);
  endfunction

  // Receiver stalls at random; estimates are checked at the rising edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_estimates.size() == 0) begin
        $error("estimate: unexpected item with value %0d", out_estimate);
        fail_count++;
      end else begin
        if (out_estimate !== pending_estimates[0]) begin
          $error("estimate: expected %0d, got %0d", pending_estimates[0], out_estimate);
          fail_count++;
        end
        void'(pending_estimates.pop_front());
      end
    end
  end

  // Watchdog on cycles with no item moving on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int          level;
    logic [31:0] qv;
    logic [4:0]  wv;

    x_now = 0; x_prev = 0; p_cov = '0; r_noise = '0;
    q_reg = 32'd4295; win_reg = 5'd7;
    pos = 0; win_sum = '0; win_sq = '0;
    foreach (ring[i]) ring[i] = '0;

    // After reset the gain is exactly one, so the first estimate is the sample itself.
    rows[0]  = '{16'sh7FFF, 1'b1, 32'sh7FFF_0000};
    rows[1]  = '{16'sh8000, 1'b0, '0};
    rows[2]  = '{16'sh7FFF, 1'b0, '0};
    rows[3]  = '{16'sh8000, 1'b0, '0};
    rows[4]  = '{16'sh7FFF, 1'b0, '0};
    rows[5]  = '{16'sh0000, 1'b0, '0};
    rows[6]  = '{16'sh0001, 1'b0, '0};
    rows[7]  = '{16'shFFFF, 1'b0, '0};
    rows[8]  = '{16'sh5555, 1'b0, '0};
    rows[9]  = '{16'shAAAA, 1'b0, '0};
    rows[10] = '{16'sh0100, 1'b0, '0};
    rows[11] = '{16'sh0100, 1'b0, '0};
    rows[12] = '{16'sh0100, 1'b0, '0};
    rows[13] = '{16'sh7FFF, 1'b0, '0};
    rows[14] = '{16'sh7FFF, 1'b0, '0};
    rows[15] = '{16'sh7FFF, 1'b0, '0};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed items with the reset settings.
    foreach (rows[i]) send_sample(rows[i].smp, rows[i].typed, rows[i].want);
    drain();

    // No process noise and a one-slot window: the gain denominator goes to zero.
    write_reg(akf_pkg::REG_PROCESS_NOISE, 32'd0);
    write_reg(akf_pkg::REG_WINDOW, 32'd0);
    write_reg(akf_pkg::CIDX_W'(2), 32'hFFFF_FFFF);
    write_reg(akf_pkg::CIDX_W'(3), 32'h1234_5678);
    send_sample(16'sh1234, 1'b0, '0);
    send_sample(16'sh8000, 1'b0, '0);
    send_sample(16'sh7FFF, 1'b0, '0);
    drain();

    // Random phases across settings and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin qv = 32'hFFFF_FFFF; wv = 5'd31; end
        1: begin qv = 32'd0;         wv = 5'd1;  end
        2: begin qv = 32'd4295;      wv = 5'd7;  end
        3: begin qv = $urandom;      wv = 5'($urandom); end
        4: begin qv = 32'd1;         wv = 5'd0;  end
        5: begin qv = $urandom;      wv = 5'd15; end
        6: begin qv = 32'h8000_0000; wv = 5'd31; end
        default: begin qv = $urandom; wv = 5'($urandom); end
      endcase
      write_reg(akf_pkg::REG_PROCESS_NOISE, qv);
      write_reg(akf_pkg::REG_WINDOW, {27'($urandom), wv});
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      level = $urandom_range(65535) - 32768;
      for (int n = 0; n < 225; n++) begin
        if ($urandom_range(49) == 0) level = $urandom_range(65535) - 32768;
        send_sample(random_sample(level), 1'b0, '0);
      end
      drain();
      idle_pct  = 0;
      stall_pct = 0;
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
